@@ hdl/ates_pkg.sv @@
// shared constants, command codes and table port structs for the alias sampler
package ates_pkg;

  localparam int MAX_BINS    = 1024;
  localparam int FRAC_BITS   = 24;
  localparam int ENERGY_BITS = 32;

  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int IDX_W      = $clog2(MAX_BINS + 1);
  localparam int EDGE_DEPTH = MAX_BINS + 1;

  // slave tdata layout, lowest field first
  localparam int IDX_LO   = 0;
  localparam int EV_LO    = IDX_LO + IDX_W;
  localparam int WV_LO    = EV_LO + ENERGY_BITS;
  localparam int AV_LO    = WV_LO + FRAC_BITS;
  localparam int RB_LO    = AV_LO + BIN_W;
  localparam int RP_LO    = RB_LO + FRAC_BITS;
  localparam int S_USED_W = RP_LO + FRAC_BITS;
  localparam int S_DATA_W = ((S_USED_W + 7) / 8) * 8;
  localparam int S_USER_W = 8;

  // master tdata layout
  localparam int M_USED_W = ENERGY_BITS + BIN_W;
  localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                   wt_we;
    logic [BIN_W-1:0]       wt_waddr;
    logic [FRAC_BITS-1:0]   wt_wdata;
    logic [BIN_W-1:0]       al_wdata;
    logic                   wt_re;
    logic [BIN_W-1:0]       wt_raddr;
    logic                   ed_we;
    logic [IDX_W-1:0]       ed_waddr;
    logic [ENERGY_BITS-1:0] ed_wdata;
    logic                   ed_re;
    logic [IDX_W-1:0]       ed_raddr_lo;
    logic [IDX_W-1:0]       ed_raddr_hi;
  } tbl_req_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0]   wt_rdata;
    logic [BIN_W-1:0]       al_rdata;
    logic [ENERGY_BITS-1:0] ed_rdata_lo;
    logic [ENERGY_BITS-1:0] ed_rdata_hi;
  } tbl_rsp_t;

endpackage

@@ hdl/ates_tables.sv @@
// weight, alias and edge energy memories with registered read data
module ates_tables
  import ates_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  logic [FRAC_BITS-1:0]   weight_mem [0:MAX_BINS-1];
  logic [BIN_W-1:0]       alias_mem  [0:MAX_BINS-1];
  logic [ENERGY_BITS-1:0] edge_mem   [0:EDGE_DEPTH-1];

  // weight and alias share a write port and a read port; edges have one write and two read ports
  always_ff @(posedge clk) begin
    if (req.wt_we) begin
      weight_mem[req.wt_waddr] <= req.wt_wdata;
      alias_mem[req.wt_waddr]  <= req.al_wdata;
    end
    if (req.wt_re) begin
      rsp.wt_rdata <= weight_mem[req.wt_raddr];
      rsp.al_rdata <= alias_mem[req.wt_raddr];
    end
    if (req.ed_we) begin
      edge_mem[req.ed_waddr] <= req.ed_wdata;
    end
    if (req.ed_re) begin
      rsp.ed_rdata_lo <= edge_mem[req.ed_raddr_lo];
      rsp.ed_rdata_hi <= edge_mem[req.ed_raddr_hi];
    end
  end

endmodule

@@ hdl/alias_table_energy_sampler.sv @@
// walker alias energy sampler: six-stage pipeline around the bin tables
//
//  channel  direction  handshake                 payload
//  s_*      in         s_tvalid / s_tready       tuser cmd, tdata write and random fields
//  m_*      out        m_tvalid / m_tready       tdata energy, chosen bin
//  cfg_*    in         cfg_valid / cfg_ready     num_bins
//
// one item enters per cycle unless m_tready stalls; a sample passes each stage register
// stages: bin multiply, weight/alias read, alias choice and edge read, edge difference,
// 32x24 position multiply, final add into the output register
// writes take effect at the stage that reads the same table, so order is kept
// stalls back up stage by stage; empty stages fill, nothing is dropped or repeated
// reset sets num_bins to one and empties the pipeline; tables are not cleared
module alias_table_energy_sampler
  import ates_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // cmd[1:0], zero fill
  input  logic [S_USER_W-1:0] s_tuser,
  // index, edge_value, weight_value, alias_value, rand_bin, rand_pos, zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // energy, chosen_bin, zero fill
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_data
);

  // configuration, kept already clamped
  logic [IDX_W-1:0] n_eff;
  logic [BIN_W-1:0] n_m1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff <= IDX_W'(1);
      n_m1  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        n_eff <= IDX_W'(1);
        n_m1  <= '0;
      end else if (cfg_data > IDX_W'(MAX_BINS)) begin
        n_eff <= IDX_W'(MAX_BINS);
        n_m1  <= BIN_W'(MAX_BINS - 1);
      end else begin
        n_eff <= cfg_data;
        n_m1  <= BIN_W'(cfg_data - IDX_W'(1));
      end
    end
  end

  // stage valids and ready chain
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !v6 || m_tready;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v6;

  // stage 1: bin product
  logic [FRAC_BITS+IDX_W-1:0] prod;
  logic [FRAC_BITS-1:0]       rb_in;
  cmd_t                       cmd1;
  logic [IDX_W-1:0]           idx1;
  logic [ENERGY_BITS-1:0]     ev1;
  logic [FRAC_BITS-1:0]       wv1;
  logic [BIN_W-1:0]           av1;
  logic [FRAC_BITS-1:0]       rp1;
  logic [IDX_W-1:0]           bin_raw1;
  logic [FRAC_BITS-1:0]       rem1;

  assign rb_in = s_tdata[RB_LO +: FRAC_BITS];
  assign prod  = {{IDX_W{1'b0}}, rb_in} * {{FRAC_BITS{1'b0}}, n_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1     <= cmd_t'(s_tuser[1:0]);
      idx1     <= s_tdata[IDX_LO +: IDX_W];
      ev1      <= s_tdata[EV_LO +: ENERGY_BITS];
      wv1      <= s_tdata[WV_LO +: FRAC_BITS];
      av1      <= s_tdata[AV_LO +: BIN_W];
      rp1      <= s_tdata[RP_LO +: FRAC_BITS];
      bin_raw1 <= prod[FRAC_BITS +: IDX_W];
      rem1     <= prod[FRAC_BITS-1:0];
    end
  end

  // clamp to the last bin in use
  logic [BIN_W-1:0] bin_c;
  assign bin_c = (bin_raw1 > {1'b0, n_m1}) ? n_m1 : bin_raw1[BIN_W-1:0];

  // stage 2: weight and alias read
  tbl_req_t               req;
  tbl_rsp_t               rsp;
  cmd_t                   cmd2;
  logic [IDX_W-1:0]       idx2;
  logic [ENERGY_BITS-1:0] ev2;
  logic [FRAC_BITS-1:0]   rp2;
  logic [BIN_W-1:0]       bin2;
  logic [BIN_W-1:0]       nm2;
  logic [FRAC_BITS-1:0]   rem2;
  logic [BIN_W-1:0]       chosen;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cmd2 <= cmd1;
      idx2 <= idx1;
      ev2  <= ev1;
      rp2  <= rp1;
      bin2 <= bin_c;
      nm2  <= n_m1;
      rem2 <= rem1;
    end
  end

  assign chosen = (rem2 > rsp.wt_rdata) ? rsp.al_rdata : bin2;

  always_comb begin
    req.wt_we       = v1 && rdy2 && (cmd1 == CMD_WEIGHT) && (idx1 < IDX_W'(MAX_BINS));
    req.wt_waddr    = idx1[BIN_W-1:0];
    req.wt_wdata    = wv1;
    req.al_wdata    = av1;
    req.wt_re       = rdy2;
    req.wt_raddr    = bin_c;
    req.ed_we       = v2 && rdy3 && (cmd2 == CMD_EDGE) && (idx2 <= IDX_W'(MAX_BINS));
    req.ed_waddr    = idx2;
    req.ed_wdata    = ev2;
    req.ed_re       = rdy3;
    req.ed_raddr_lo = {1'b0, chosen};
    req.ed_raddr_hi = {1'b0, chosen} + IDX_W'(1);
  end

  ates_tables u_tables (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // stage 3: edges read, only samples travel on from here
  logic [BIN_W-1:0]     bin3;
  logic [FRAC_BITS-1:0] rp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2 && (cmd2 == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      bin3 <= chosen;
      rp3  <= rp2;
    end
  end

  // stage 4: bin width and direction
  logic                   up4;
  logic [ENERGY_BITS-1:0] diff4;
  logic [ENERGY_BITS-1:0] lo4;
  logic [FRAC_BITS-1:0]   rp4;
  logic [BIN_W-1:0]       bin4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      up4   <= rsp.ed_rdata_hi >= rsp.ed_rdata_lo;
      diff4 <= (rsp.ed_rdata_hi >= rsp.ed_rdata_lo) ? rsp.ed_rdata_hi - rsp.ed_rdata_lo
                                                    : rsp.ed_rdata_lo - rsp.ed_rdata_hi;
      lo4   <= rsp.ed_rdata_lo;
      rp4   <= rp3;
      bin4  <= bin3;
    end
  end

  // stage 5: position within the bin
  logic [ENERGY_BITS+FRAC_BITS-1:0] pos_prod;
  logic                             up5;
  logic [ENERGY_BITS-1:0]           scl5;
  logic [ENERGY_BITS-1:0]           diff5;
  logic [ENERGY_BITS-1:0]           lo5;
  logic [BIN_W-1:0]                 bin5;

  assign pos_prod = {{FRAC_BITS{1'b0}}, diff4} * {{ENERGY_BITS{1'b0}}, rp4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      up5   <= up4;
      scl5  <= pos_prod[FRAC_BITS +: ENERGY_BITS];
      diff5 <= diff4;
      lo5   <= lo4;
      bin5  <= bin4;
    end
  end

  // stage 6: output register
  logic [ENERGY_BITS-1:0] energy6;
  logic [BIN_W-1:0]       bin6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      energy6 <= up5 ? lo5 + scl5 : lo5 - scl5;
      bin6    <= bin5;
    end
  end

  assign m_tdata = {{(M_DATA_W - M_USED_W){1'b0}}, bin6, energy6};

  // checks
  a_bin_clamped: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (bin2 <= nm2))
    else $error("bin beyond last bin in use");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !v6 |-> s_tready)
    else $error("input held off with empty output register");

  a_edge_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy4) |=> (v3 && $stable(rsp.ed_rdata_lo) && $stable(rsp.ed_rdata_hi)))
    else $error("edge read data lost during stall");

  a_pos_in_bin: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (scl5 <= diff5))
    else $error("position offset exceeds bin width");

endmodule
